// ===== rtl/m4vt_pkg.sv =====
// Shared types, opcodes and constants of the 4x4 matrix vector transform unit.
`default_nettype none

package m4vt_pkg;

  localparam int unsigned ELEM_W   = 16;
  localparam int unsigned NUM_COMP = 4;
  localparam int unsigned COEF_W   = 64;
  localparam int unsigned ACC_W    = 42;
  localparam int unsigned OP_W     = 3;

  typedef logic signed [ELEM_W-1:0]   elem_t;
  typedef logic signed [2*ELEM_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [OP_W-1:0]            opcode_t;
  typedef logic [NUM_COMP-1:0][COEF_W-1:0] coef_mat_t;

  localparam opcode_t OP_FULL4      = 3'd0;
  localparam opcode_t OP_POINT3     = 3'd1;
  localparam opcode_t OP_ROTATE3    = 3'd2;
  localparam opcode_t OP_INVROTATE3 = 3'd3;
  localparam opcode_t OP_ROTATE4    = 3'd4;
  localparam opcode_t OP_INVROTATE4 = 3'd5;

  localparam acc_t ACC_ELEM_MAX = acc_t'(2 ** (ELEM_W - 1) - 1);
  localparam acc_t ACC_ELEM_MIN = acc_t'(-(2 ** (ELEM_W - 1)));
  localparam elem_t ELEM_MAX    = elem_t'(2 ** (ELEM_W - 1) - 1);
  localparam elem_t ELEM_MIN    = elem_t'(-(2 ** (ELEM_W - 1)));

  localparam coef_mat_t COEF_RESET = {
    64'h0100_0000_0000_0000,
    64'h0000_0100_0000_0000,
    64'h0000_0000_0100_0000,
    64'h0000_0000_0000_0100
  };

  typedef struct packed {
    opcode_t                    opcode;
    elem_t [NUM_COMP-1:0]       vec;
    acc_t  [NUM_COMP-1:0]       sum;
  } stage_t;

  function automatic elem_t coef_at(coef_mat_t m, logic [1:0] row, logic [1:0] col);
    return m[row][col*ELEM_W +: ELEM_W];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/m4vt_cell.sv =====
// One column cell: adds one component's column terms to the four running sums.
`default_nettype none

module m4vt_cell #(
  parameter int unsigned Col          = 0,
  parameter int unsigned FractionBits = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire m4vt_pkg::coef_mat_t coef_i,
  input  wire logic                valid_i,
  input  wire m4vt_pkg::stage_t    data_i,
  output logic                     ready_o,
  output logic                     valid_o,
  output m4vt_pkg::stage_t         data_o,
  input  wire logic                ready_i
);

  logic             valid_q;
  m4vt_pkg::stage_t data_q, data_d;
  logic             transposed;
  m4vt_pkg::elem_t  coef   [m4vt_pkg::NUM_COMP];
  m4vt_pkg::prod_t  prod   [m4vt_pkg::NUM_COMP];
  m4vt_pkg::acc_t   term   [m4vt_pkg::NUM_COMP];

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    transposed = (data_i.opcode == m4vt_pkg::OP_INVROTATE3) ||
                 (data_i.opcode == m4vt_pkg::OP_INVROTATE4);
    data_d = data_i;
    for (int r = 0; r < m4vt_pkg::NUM_COMP; r++) begin
      coef[r] = transposed ? m4vt_pkg::coef_at(coef_i, 2'(Col), 2'(r))
                           : m4vt_pkg::coef_at(coef_i, 2'(r), 2'(Col));
      prod[r] = m4vt_pkg::prod_t'(coef[r]) * m4vt_pkg::prod_t'(data_i.vec[Col]);
      term[r] = m4vt_pkg::acc_t'($signed(prod[r]));
      if (Col == m4vt_pkg::NUM_COMP - 1) begin
        if (data_i.opcode == m4vt_pkg::OP_POINT3) begin
          term[r] = m4vt_pkg::acc_t'($signed(coef[r])) <<< FractionBits;
        end else if (data_i.opcode == m4vt_pkg::OP_ROTATE3 ||
                     data_i.opcode == m4vt_pkg::OP_INVROTATE3) begin
          term[r] = '0;
        end
      end
      data_d.sum[r] = $signed(data_i.sum[r]) + $signed(term[r]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m4vt_sat.sv =====
// Output stage: shift, saturate, mask unused components and hold the result.
`default_nettype none

module m4vt_sat #(
  parameter int unsigned FractionBits = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire m4vt_pkg::stage_t data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output logic [m4vt_pkg::NUM_COMP*m4vt_pkg::ELEM_W-1:0] data_o,
  output logic                  sat_o,
  input  wire logic             ready_i
);

  logic valid_q;
  logic [m4vt_pkg::NUM_COMP*m4vt_pkg::ELEM_W-1:0] data_q, data_d;
  logic sat_q, sat_d;
  logic op_ok;
  m4vt_pkg::acc_t  shifted [m4vt_pkg::NUM_COMP];
  m4vt_pkg::elem_t value   [m4vt_pkg::NUM_COMP];
  logic [m4vt_pkg::NUM_COMP-1:0] active, over, under;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign sat_o   = sat_q;

  always_comb begin
    op_ok  = (data_i.opcode <= m4vt_pkg::OP_INVROTATE4);
    sat_d  = 1'b0;
    data_d = '0;
    for (int r = 0; r < m4vt_pkg::NUM_COMP; r++) begin
      shifted[r] = $signed(data_i.sum[r]) >>> FractionBits;
      over[r]    = $signed(shifted[r]) > $signed(m4vt_pkg::ACC_ELEM_MAX);
      under[r]   = $signed(shifted[r]) < $signed(m4vt_pkg::ACC_ELEM_MIN);
      active[r]  = op_ok && ((r < m4vt_pkg::NUM_COMP - 1) ||
                             (data_i.opcode == m4vt_pkg::OP_FULL4));
      if (over[r]) begin
        value[r] = m4vt_pkg::ELEM_MAX;
      end else if (under[r]) begin
        value[r] = m4vt_pkg::ELEM_MIN;
      end else begin
        value[r] = shifted[r][m4vt_pkg::ELEM_W-1:0];
      end
      if (active[r]) begin
        data_d[r*m4vt_pkg::ELEM_W +: m4vt_pkg::ELEM_W] = value[r];
        sat_d = sat_d | over[r] | under[r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
      sat_q  <= sat_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/matrix4_vector_transform_unit.sv =====
// Fixed-point 4x4 matrix times vector transform unit, top level.
//
// Usage:
//   Write the four matrix rows through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while no transfer is in flight; index 0..3 selects row x, y, z, w.
//   Each row holds four signed Q8.8 coefficients, column x in bits 15:0.
//   Input transfers carry the vector on s_axis_tdata and the opcode on
//   s_axis_tuser; each yields exactly one output transfer carrying the
//   transformed vector on m_axis_tdata and the saturation flag on m_axis_tuser.
//   Each transfer is registered in each of the four column cells, which add
//   one column of products each to the running sums, then in the shift and
//   saturate stage. Throughput is one vector per cycle when not stalled.
//   When the receiver stalls, results back up stage by stage; empty stages
//   still take new transfers, so the input stalls only once the chain is full.
//   Reset empties the chain and loads the identity matrix.
`default_nettype none

module matrix4_vector_transform_unit #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // in_x, in_y, in_z, in_w
  input  wire logic [2:0]  s_axis_tuser,  // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // out_x, out_y, out_z, out_w
  output logic             m_axis_tuser   // saturated
);

  m4vt_pkg::coef_mat_t coef_q;
  m4vt_pkg::stage_t    stage_data  [m4vt_pkg::NUM_COMP+1];
  logic                stage_valid [m4vt_pkg::NUM_COMP+1];
  logic                stage_ready [m4vt_pkg::NUM_COMP+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= m4vt_pkg::COEF_RESET;
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    stage_data[0].opcode = s_axis_tuser;
    for (int c = 0; c < m4vt_pkg::NUM_COMP; c++) begin
      stage_data[0].vec[c] = s_axis_tdata[c*m4vt_pkg::ELEM_W +: m4vt_pkg::ELEM_W];
      stage_data[0].sum[c] = '0;
    end
  end

  assign stage_valid[0] = s_axis_tvalid;
  assign s_axis_tready  = stage_ready[0];

  for (genvar c = 0; c < m4vt_pkg::NUM_COMP; c++) begin : g_cell
    m4vt_cell #(
      .Col          (c),
      .FractionBits (FRACTION_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .coef_i  (coef_q),
      .valid_i (stage_valid[c]),
      .data_i  (stage_data[c]),
      .ready_o (stage_ready[c]),
      .valid_o (stage_valid[c+1]),
      .data_o  (stage_data[c+1]),
      .ready_i (stage_ready[c+1])
    );
  end

  m4vt_sat #(
    .FractionBits (FRACTION_BITS)
  ) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid[m4vt_pkg::NUM_COMP]),
    .data_i  (stage_data[m4vt_pkg::NUM_COMP]),
    .ready_o (stage_ready[m4vt_pkg::NUM_COMP]),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata),
    .sat_o   (m_axis_tuser),
    .ready_i (m_axis_tready)
  );

endmodule

`default_nettype wire
